// ===== rtl/stbi_pkg.sv =====
package stbi_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int KEY_W_DEF = 32;

  // Fixed widths of the index fields on the ports.
  localparam int POS_W = 11;
  localparam int LO_W  = 12;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LO_NEG = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic       load;
    logic       probe;
    logic       compare;
    logic       setup;
    logic       shift;
    logic       write_key;
    logic       emit;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic lo_neg;
    logic empty;
    logic beyond;
    logic insert;
    logic full;
    logic append;
    logic shift_last;
  } sts_t;

endpackage

// ===== rtl/stbi_ctrl.sv =====
module stbi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  stbi_pkg::sts_t sts,
  output stbi_pkg::cmd_t cmd,
  output logic          busy
);
  import stbi_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_COMPARE = 3'd2;
  localparam logic [2:0] S_POST    = 3'd3;
  localparam logic [2:0] S_SHIFT   = 3'd4;
  localparam logic [2:0] S_WRITE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.code = ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.lo_neg) begin
          cmd.emit = 1'b1;
          cmd.code = ST_LO_NEG;
          state_next = S_IDLE;
        end else if (sts.empty) begin
          state_next = S_POST;
        end else if (sts.beyond) begin
          cmd.emit = 1'b1;
          cmd.code = ST_BEYOND;
          state_next = S_IDLE;
        end else begin
          cmd.probe = 1'b1;
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        state_next = S_CHECK;
      end
      S_POST: begin
        if (!sts.insert) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end else if (sts.full) begin
          cmd.emit = 1'b1;
          cmd.code = ST_FULL;
          state_next = S_IDLE;
        end else begin
          cmd.setup = 1'b1;
          state_next = sts.append ? S_WRITE : S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_key = 1'b1;
        cmd.emit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/stbi_dpath.sv =====
module stbi_dpath #(
  parameter int DEPTH     = stbi_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = stbi_pkg::KEY_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  stbi_pkg::cmd_t             cmd,
  output stbi_pkg::sts_t             sts,
  input  logic                       action,
  input  logic                       direction,
  input  logic [KEY_WIDTH-1:0]       key_value,
  input  logic [stbi_pkg::LO_W-1:0]  lo_bound,
  input  logic                       hi_given,
  input  logic [stbi_pkg::POS_W-1:0] hi_bound,
  output logic                       done,
  output logic [stbi_pkg::POS_W-1:0] position,
  output logic [1:0]                 status,
  output logic [stbi_pkg::POS_W-1:0] entry_count
);
  import stbi_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;

  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rdata;

  logic [KEY_WIDTH-1:0] key_r;
  logic                 action_r;
  logic                 dir_r;
  logic                 lo_neg_r;
  logic [IW-1:0]        lo;
  logic [IW-1:0]        hi;
  logic [IW-1:0]        mid;
  logic [CW-1:0]        count;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        ins;

  logic [IW:0]          sum;
  logic [IW-1:0]        mid_c;
  logic [CW-1:0]        ptr_dec;
  logic [CW-1:0]        ptr_dec2;
  logic [CW-1:0]        count_dec;
  logic                 go_right;
  logic                 rd_en;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wdata;

  assign sum       = {1'b0, lo} + {1'b0, hi};
  assign mid_c     = sum[IW:1];
  assign ptr_dec   = ptr - CW'(1);
  assign ptr_dec2  = ptr - CW'(2);
  assign count_dec = count - CW'(1);

  // Left mode moves right past entries below the key; right mode also past equal ones.
  assign go_right = dir_r ? !(key_r < rdata) : (rdata < key_r);

  assign sts.lo_neg     = lo_neg_r;
  assign sts.empty      = !(lo < hi);
  assign sts.beyond     = (mid_c >= IW'(count));
  assign sts.insert     = action_r;
  assign sts.full       = (count == CW'(DEPTH));
  assign sts.append     = (lo >= IW'(count));
  assign sts.shift_last = (ptr_dec == ins);

  always_comb begin
    rd_en = 1'b0;
    raddr = mid_c[AW-1:0];
    if (cmd.probe) begin
      rd_en = 1'b1;
    end else if (cmd.setup) begin
      rd_en = !sts.append;
      raddr = count_dec[AW-1:0];
    end else if (cmd.shift) begin
      rd_en = !sts.shift_last;
      raddr = ptr_dec2[AW-1:0];
    end
  end

  assign we    = cmd.shift | cmd.write_key;
  assign waddr = cmd.shift ? ptr[AW-1:0] : ins[AW-1:0];
  assign wdata = cmd.shift ? rdata : key_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= key_value;
      action_r <= action;
      dir_r    <= direction;
      lo_neg_r <= lo_bound[LO_W-1];
      lo       <= IW'(lo_bound[LO_W-2:0]);
      hi       <= hi_given ? IW'(hi_bound) : IW'(count);
    end else if (cmd.compare) begin
      if (go_right) begin
        lo <= mid + IW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.probe) begin
      mid <= mid_c;
    end
    if (cmd.setup) begin
      ptr <= count;
      ins <= sts.append ? count : CW'(lo);
    end else if (cmd.shift) begin
      ptr <= ptr_dec;
    end
    if (cmd.emit) begin
      status   <= cmd.code;
      position <= (cmd.code == ST_OK || cmd.code == ST_FULL) ? POS_W'(lo) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.write_key) begin
        count <= count + CW'(1);
      end
    end
  end

  assign entry_count = POS_W'(count);

endmodule

// ===== rtl/sorted_table_bisect_insert.sv =====
// From the accepting edge, each search probe is a memory read and then a compare, a final
// range check follows and the result is posted (an error found in a check is posted at
// once), and on insert the entries are shifted and then the key is written; done is high
// the cycle after the result is emitted. One word is handled at a time, the next taken in
// the done cycle; while shifting, one memory read and write per cycle shift one entry each.
// Reset clears the entry count and controller, not the keys; the receiver cannot stall done.
module sorted_table_bisect_insert #(
  parameter int DEPTH     = stbi_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = stbi_pkg::KEY_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  logic                       direction,
  input  logic [KEY_WIDTH-1:0]       key_value,
  input  logic [stbi_pkg::LO_W-1:0]  lo_bound,
  input  logic                       hi_given,
  input  logic [stbi_pkg::POS_W-1:0] hi_bound,
  output logic                       done,
  output logic [stbi_pkg::POS_W-1:0] position,
  output logic [1:0]                 status,
  output logic [stbi_pkg::POS_W-1:0] entry_count
);
  import stbi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stbi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  stbi_dpath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (action),
    .direction   (direction),
    .key_value   (key_value),
    .lo_bound    (lo_bound),
    .hi_given    (hi_given),
    .hi_bound    (hi_bound),
    .done        (done),
    .position    (position),
    .status      (status),
    .entry_count (entry_count)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word shown while still busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not make the block busy");

  a_err_pos: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_LO_NEG || status == ST_BEYOND) |-> position == '0)
    else $error("error result carries a nonzero position");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && entry_count != $past(entry_count) |-> done && status == ST_OK)
    else $error("entry count changed without a successful result");

endmodule

// ===== dv/tb_sorted_table_bisect_insert.sv =====
`timescale 1ns / 100ps

module tb_sorted_table_bisect_insert;
  import stbi_pkg::*;

  localparam int TBL_DEPTH  = DEPTH_DEF;
  localparam int KEY_W      = KEY_W_DEF;
  localparam int RAND_WORDS = 1800;
  localparam int STALL_MAX  = 8000;
  localparam int DRAIN_EACH = 400;

  localparam logic ACT_SEARCH = 1'b0;
  localparam logic ACT_INSERT = 1'b1;
  localparam logic DIR_LEFT   = 1'b0;
  localparam logic DIR_RIGHT  = 1'b1;
  localparam logic HI_COUNT   = 1'b0;
  localparam logic HI_GIVEN   = 1'b1;

  typedef struct packed {
    logic             action;
    logic             direction;
    logic [KEY_W-1:0] key;
    logic [LO_W-1:0]  lo;
    logic             hi_given;
    logic [POS_W-1:0] hi;
  } search_req_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [1:0]       st;
    logic [POS_W-1:0] cnt;
  } search_res_t;

  // One directed word; when typed is set, the result columns are the expectation.
  typedef struct packed {
    logic             act;
    logic             dir;
    logic [KEY_W-1:0] key;
    logic [LO_W-1:0]  lo;
    logic             hg;
    logic [POS_W-1:0] hi;
    logic             typed;
    logic [POS_W-1:0] pos;
    logic [1:0]       st;
    logic [POS_W-1:0] cnt;
  } word_row_t;

  localparam int NUM_ROWS = 21;
  localparam word_row_t DIR_ROWS [NUM_ROWS] = '{
    // act        dir        key            lo         hg        hi      typed pos     st
    '{ACT_SEARCH, DIR_LEFT,  32'd5,         12'd0,    HI_COUNT, 11'd0,    1'b1, 11'd0,
       ST_OK,     11'd0},
    '{ACT_SEARCH, DIR_LEFT,  32'd5,         12'hFFF,  HI_COUNT, 11'd0,    1'b1, 11'd0,
       ST_LO_NEG, 11'd0},
    '{ACT_INSERT, DIR_RIGHT, 32'd9,         12'h800,  HI_COUNT, 11'd0,    1'b1, 11'd0,
       ST_LO_NEG, 11'd0},
    '{ACT_SEARCH, DIR_LEFT,  32'd9,         12'd0,    HI_GIVEN, 11'd1,    1'b1, 11'd0,
       ST_BEYOND, 11'd0},
    '{ACT_INSERT, DIR_LEFT,  32'd0,         12'd0,    HI_COUNT, 11'd0,    1'b1, 11'd0,
       ST_OK,     11'd1},
    '{ACT_INSERT, DIR_RIGHT, 32'hFFFFFFFF,  12'd0,    HI_COUNT, 11'd0,    1'b1, 11'd1,
       ST_OK,     11'd2},
    '{ACT_INSERT, DIR_LEFT,  32'd100,       12'd0,    HI_COUNT, 11'd0,    1'b0, 11'd0,
       ST_OK,     11'd0},
    '{ACT_INSERT, DIR_LEFT,  32'd100,       12'd0,    HI_COUNT, 11'd0,    1'b0, 11'd0,
       ST_OK,     11'd0},
    '{ACT_INSERT, DIR_RIGHT, 32'd100,       12'd0,    HI_COUNT, 11'd0,    1'b0, 11'd0,
       ST_OK,     11'd0},
    '{ACT_SEARCH, DIR_LEFT,  32'd100,       12'd0,    HI_COUNT, 11'd0,    1'b0, 11'd0,
       ST_OK,     11'd0},
    '{ACT_SEARCH, DIR_RIGHT, 32'd100,       12'd0,    HI_COUNT, 11'd0,    1'b0, 11'd0,
       ST_OK,     11'd0},
    '{ACT_INSERT, DIR_RIGHT, 32'd0,         12'd0,    HI_COUNT, 11'd0,    1'b0, 11'd0,
       ST_OK,     11'd0},
    '{ACT_SEARCH, DIR_LEFT,  32'd50,        12'd3,    HI_GIVEN, 11'd2,    1'b1, 11'd3,
       ST_OK,     11'd6},
    '{ACT_INSERT, DIR_LEFT,  32'hFFFFFFFF,  12'h400,  HI_GIVEN, 11'd0,    1'b1, 11'd1024,
       ST_OK,     11'd7},
    '{ACT_SEARCH, DIR_RIGHT, 32'd0,         12'h7FF,  HI_COUNT, 11'd0,    1'b1, 11'd2047,
       ST_OK,     11'd7},
    '{ACT_SEARCH, DIR_LEFT,  32'd1,         12'd0,    HI_GIVEN, 11'h7FF,  1'b1, 11'd0,
       ST_BEYOND, 11'd7},
    '{ACT_SEARCH, DIR_RIGHT, 32'd100,       12'd0,    HI_GIVEN, 11'd7,    1'b0, 11'd0,
       ST_OK,     11'd0},
    '{ACT_SEARCH, DIR_LEFT,  32'd100,       12'd2,    HI_GIVEN, 11'd6,    1'b0, 11'd0,
       ST_OK,     11'd0},
    '{ACT_SEARCH, DIR_RIGHT, 32'hFFFFFFFF,  12'd0,    HI_COUNT, 11'd0,    1'b0, 11'd0,
       ST_OK,     11'd0},
    '{ACT_SEARCH, DIR_LEFT,  32'd3,         12'h400,  HI_COUNT, 11'd0,    1'b1, 11'd1024,
       ST_OK,     11'd7},
    '{ACT_INSERT, DIR_LEFT,  32'd50,        12'd0,    HI_GIVEN, 11'd9,    1'b0, 11'd0,
       ST_OK,     11'd0}
  };

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             action    = 1'b0;
  logic             direction = 1'b0;
  logic [KEY_W-1:0] key_value = '0;
  logic [LO_W-1:0]  lo_bound  = '0;
  logic             hi_given  = 1'b0;
  logic [POS_W-1:0] hi_bound  = '0;
  logic             busy;
  logic             done;
  logic [POS_W-1:0] position;
  logic [1:0]       status;
  logic [POS_W-1:0] entry_count;

  // Shadow copy of the sorted table, updated as each word is accepted.
  logic [KEY_W-1:0] tbl_keys [TBL_DEPTH];
  int               tbl_count = 0;

  search_res_t pending_results [$];
  search_res_t head_res;
  int          mismatches    = 0;
  int          words_sent    = 0;
  int          words_checked = 0;
  int          keys_stored   = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          stall_cycles  = 0;

  always #2 clk = ~clk;

  sorted_table_bisect_insert DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .direction   (direction),
    .key_value   (key_value),
    .lo_bound    (lo_bound),
    .hi_given    (hi_given),
    .hi_bound    (hi_bound),
    .done        (done),
    .position    (position),
    .status      (status),
    .entry_count (entry_count)
  );

  function automatic search_res_t predict_bisect(search_req_t r);
    search_res_t res;
    int lo, hi, mid, at, i;
    res.pos = '0;
    res.st  = ST_OK;
    res.cnt = tbl_count[POS_W-1:0];
    if (r.lo[LO_W-1]) begin
      res.st = ST_LO_NEG;
      return res;
    end
    lo = int'(r.lo);
    hi = r.hi_given ? int'(r.hi) : tbl_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (mid >= tbl_count || mid >= TBL_DEPTH) begin
        res.st = ST_BEYOND;
        return res;
      end
      if (r.direction == DIR_LEFT) begin
        if (tbl_keys[mid] < r.key) lo = mid + 1;
        else hi = mid;
      end else begin
        if (r.key < tbl_keys[mid]) hi = mid;
        else lo = mid + 1;
      end
    end
    res.pos = lo[POS_W-1:0];
    if (r.action == ACT_INSERT) begin
      if (tbl_count >= TBL_DEPTH) begin
        res.st = ST_FULL;
        return res;
      end
      // A position past the end appends at the current count.
      at = (lo < tbl_count) ? lo : tbl_count;
      for (i = tbl_count; i > at; i--) tbl_keys[i] = tbl_keys[i-1];
      tbl_keys[at] = r.key;
      tbl_count++;
      keys_stored++;
      res.cnt = tbl_count[POS_W-1:0];
    end
    return res;
  endfunction

  // Most words are well formed so the table fills up; the rest probe the error paths.
  function automatic search_req_t roll_request();
    search_req_t r;
    int c, pick, low;
    c = tbl_count;
    r.action    = ($urandom_range(0, 99) < ((c < TBL_DEPTH) ? 85 : 40)) ? ACT_INSERT
                                                                        : ACT_SEARCH;
    r.direction = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 30 && c > 0) r.key = tbl_keys[$urandom_range(0, c - 1)];
    else if (pick < 50) r.key = KEY_W'($urandom_range(0, 15));
    else if (pick < 60) r.key = $urandom_range(0, 1) ? '1 : '0;
    else r.key = KEY_W'($urandom);
    r.hi_given = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 75) begin
      r.lo = ($urandom_range(0, 99) < 60) ? '0 : LO_W'($urandom_range(0, c));
      r.hi = POS_W'($urandom_range(int'(r.lo), c));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) r.lo = LO_W'($urandom_range(2048, 4095));
      else if (pick < 60) r.lo = LO_W'($urandom_range(c, 2047));
      else if (pick < 80) r.lo = LO_W'($urandom_range(0, c));
      else r.lo = LO_W'($urandom);
      low = r.lo[LO_W-1] ? 0 : int'(r.lo);
      pick = $urandom_range(0, 99);
      if (pick < 30) r.hi = POS_W'($urandom_range(0, c));
      else if (pick < 60) r.hi = POS_W'($urandom_range(c, TBL_DEPTH));
      else if (pick < 80) r.hi = POS_W'($urandom_range(low, 2047));
      else r.hi = POS_W'($urandom);
    end
    return r;
  endfunction

  task automatic issue_word(search_req_t r, bit typed, search_res_t want);
    search_res_t res;
    start     <= 1'b1;
    action    <= r.action;
    direction <= r.direction;
    key_value <= r.key;
    lo_bound  <= r.lo;
    hi_given  <= r.hi_given;
    hi_bound  <= r.hi;
    do @(posedge clk); while (busy !== 1'b0);
    res = predict_bisect(r);
    pending_results.push_back(typed ? want : res);
    words_sent++;
  endtask

  task automatic sender_gap(bit allowed);
    int n;
    n = 0;
    if (allowed) begin
      while ($urandom_range(0, 99) < 36) n++;
      if ($urandom_range(0, 99) < 5) n += $urandom_range(1, 40);
    end
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatches < 40)
      $display("mismatch in %s at result %0d: got %0d, expected %0d",
               what, words_checked, got, want);
    mismatches++;
  endtask

  // Outputs are stable between rising edges, so the checker samples mid-cycle.
  always @(negedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no word pending", int'(position), -1);
      end else begin
        head_res = pending_results.pop_front();
        if (position !== head_res.pos)
          flag_mismatch("position", int'(position), int'(head_res.pos));
        if (status !== head_res.st)
          flag_mismatch("status", int'(status), int'(head_res.st));
        if (entry_count !== head_res.cnt)
          flag_mismatch("entry_count", int'(entry_count), int'(head_res.cnt));
        status_seen[head_res.st]++;
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("no word moved for %0d cycles", STALL_MAX);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    search_req_t req;
    search_res_t want;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < NUM_ROWS; k++) begin
      req  = '{DIR_ROWS[k].act, DIR_ROWS[k].dir, DIR_ROWS[k].key, DIR_ROWS[k].lo,
               DIR_ROWS[k].hg, DIR_ROWS[k].hi};
      want = '{DIR_ROWS[k].pos, DIR_ROWS[k].st, DIR_ROWS[k].cnt};
      issue_word(req, DIR_ROWS[k].typed, want);
      sender_gap(1'b1);
    end
    hold_until_drained();

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % DRAIN_EACH == DRAIN_EACH - 1) hold_until_drained();
      req = roll_request();
      issue_word(req, 1'b0, '0);
      // Back-to-back stretch with no sender gaps at all.
      if (n != RAND_WORDS - 1) sender_gap(!(n >= 800 && n < 1100));
    end
    hold_until_drained();
    repeat (64) @(posedge clk);

    $display("sent %0d words, checked %0d results, stored %0d keys (table at %0d of %0d)",
             words_sent, words_checked, keys_stored, tbl_count, TBL_DEPTH);
    $display("status seen: ok %0d, negative lower bound %0d, probe beyond %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_LO_NEG], status_seen[ST_BEYOND],
             status_seen[ST_FULL]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
